// File: rtl/core/ldrc_pkg.sv
package ldrc_pkg;

  typedef enum logic [2:0] {
    REQ_ADD   = 3'd0,
    REQ_VIS   = 3'd1,
    REQ_INVAL = 3'd2,
    REQ_DRAW  = 3'd3,
    REQ_REDRW = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  localparam logic [1:0] ADDR_TARGET = 2'd0;
  localparam logic [1:0] ADDR_CW     = 2'd1;
  localparam logic [1:0] ADDR_CH     = 2'd2;

  // Rectangle in 18-bit signed coordinates (left/top, inclusive right/bottom).
  typedef struct packed {
    logic signed [17:0] l;
    logic signed [17:0] t;
    logic signed [17:0] r;
    logic signed [17:0] b;
  } rect_t;

  // Result of the shared rectangle unit for one pair.
  typedef struct packed {
    logic               overlap;
    logic               covers;
    logic signed [17:0] cl;
    logic signed [17:0] ct;
    logic signed [17:0] cw;
    logic signed [17:0] ch;
  } rect_res_t;

endpackage

// File: rtl/core/ldrc_rect_unit.sv
// Shared rectangle unit: overlap test, cover test and clip for a pair.
module ldrc_rect_unit (
  input  ldrc_pkg::rect_t     a_i,
  input  ldrc_pkg::rect_t     b_i,
  output ldrc_pkg::rect_res_t res_o
);

  logic signed [17:0] cr;
  logic signed [17:0] cb;

  always_comb begin
    res_o.overlap = !(a_i.t > b_i.b || a_i.l > b_i.r || a_i.r < b_i.l || a_i.b < b_i.t);
    // Cover test on exclusive right/bottom edges matches inclusive edges.
    res_o.covers  = (b_i.l <= a_i.l) && (b_i.t <= a_i.t) &&
                    (b_i.r >= a_i.r) && (b_i.b >= a_i.b);
    res_o.cl      = (b_i.l < a_i.l) ? a_i.l : b_i.l;
    res_o.ct      = (b_i.t < a_i.t) ? a_i.t : b_i.t;
    cr            = (b_i.r < a_i.r) ? b_i.r : a_i.r;
    cb            = (b_i.b < a_i.b) ? b_i.b : a_i.b;
    res_o.cw      = cr - res_o.cl + 18'sd1;
    res_o.ch      = cb - res_o.ct + 18'sd1;
  end

endmodule

// File: rtl/core/layer_dirty_rect_compositor_unit.sv
// Dirty-rectangle layer compositor, command generator.
// Usage: present a request on req_type_i and its fields and raise start
// while busy is low; the request is taken at that edge. The block then
// raises busy and walks its layer table with one shared rectangle unit,
// one layer pair per cycle. Every result appears for exactly one cycle with
// res_valid_o high and must be taken then; the receiver cannot stall.
// Each request ends with an acknowledge (is_blit_o low, last_o high).
// Add and unknown requests go straight to the acknowledge; visibility changes
// and invalidate requests first scan every other layer once. Draw walks the
// layer pairs in its clip pass, then (target on) each layer in its copy pass;
// redraw walks each layer, then the canvas copy. The pair walk through the
// shared unit sets the rate. Configuration (APB): 0 target_enabled,
// 1 canvas_width, 2 canvas_height, to be written by the user only while busy
// is low; the block does not enforce this. Reset empties the layer table and
// loads the register reset values; table contents stay undefined until added.
module layer_dirty_rect_compositor_unit #(
  parameter int MAX_LAYERS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [2:0]  layer_index_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [11:0] size_w_i,
  input  logic [11:0] size_h_i,
  input  logic        show_i,
  output logic        res_valid_o,
  output logic        dest_is_target_o,
  output logic signed [15:0] dst_x_o,
  output logic signed [15:0] dst_y_o,
  output logic        src_is_canvas_o,
  output logic [2:0]  src_layer_o,
  output logic signed [15:0] src_x_o,
  output logic signed [15:0] src_y_o,
  output logic [11:0] blit_w_o,
  output logic [11:0] blit_h_o,
  output logic        is_blit_o,
  output logic        last_o,
  output logic [1:0]  status_o
);

  localparam int IW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CW = $clog2(MAX_LAYERS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INVAL = 7'b0000010,
    S_CLIP  = 7'b0000100,
    S_COPY  = 7'b0001000,
    S_RDRW  = 7'b0010000,
    S_CANV  = 7'b0100000,
    S_ACK   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic target_q;
  logic [11:0] cw_q, ch_q;

  logic signed [15:0] left_q [MAX_LAYERS];
  logic signed [15:0] top_q  [MAX_LAYERS];
  logic [11:0] wid_q [MAX_LAYERS];
  logic [11:0] hgt_q [MAX_LAYERS];
  logic [MAX_LAYERS-1:0] vis_q, dirty_q;
  logic [CW-1:0] count_q;

  logic [IW-1:0] a_q, b_q;       // outer (dirty) and inner (source) layer
  logic [IW-1:0] tgt_q;          // layer under invalidation
  logic          covered_q;
  logic [2:0]    ack_layer_q;
  logic [1:0]    ack_status_q;

  // Result register.
  logic        rv_q, dt_q, sc_q, ib_q, la_q;
  logic signed [15:0] dx_q, dy_q, sx_q, sy_q;
  logic [2:0]  sl_q;
  logic [11:0] bw_q, bh_q;
  logic [1:0]  st_q;

  ldrc_pkg::rect_t     ra, rb;
  ldrc_pkg::rect_res_t rr;

  function automatic ldrc_pkg::rect_t mk_rect(logic signed [15:0] l, logic signed [15:0] t,
                                              logic [11:0] w, logic [11:0] h);
    ldrc_pkg::rect_t r;
    r.l = 18'(l);
    r.t = 18'(t);
    r.r = 18'(l) + $signed({6'd0, w}) - 18'sd1;
    r.b = 18'(t) + $signed({6'd0, h}) - 18'sd1;
    return r;
  endfunction

  logic [IW-1:0] ai;
  always_comb begin
    ai = (state_q == S_INVAL) ? tgt_q : a_q;
    ra = mk_rect(left_q[ai], top_q[ai], wid_q[ai], hgt_q[ai]);
    rb = mk_rect(left_q[b_q], top_q[b_q], wid_q[b_q], hgt_q[b_q]);
  end

  ldrc_rect_unit u_rect (
    .a_i  (ra),
    .b_i  (rb),
    .res_o(rr)
  );

  assign pready = 1'b1;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    unique case (paddr[3:2])
      ldrc_pkg::ADDR_TARGET: prdata = {31'd0, target_q};
      ldrc_pkg::ADDR_CW:     prdata = {20'd0, cw_q};
      ldrc_pkg::ADDR_CH:     prdata = {20'd0, ch_q};
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 1'b1;
      cw_q     <= 12'd640;
      ch_q     <= 12'd480;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        ldrc_pkg::ADDR_TARGET: target_q <= pwdata[0];
        ldrc_pkg::ADDR_CW:     cw_q     <= pwdata[11:0];
        ldrc_pkg::ADDR_CH:     ch_q     <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  logic accept;
  logic [IW-1:0] last_idx;
  assign accept   = start && !busy;
  assign last_idx = IW'(count_q - CW'(1));

  // Main sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      rv_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (accept) begin
          ack_layer_q  <= 3'd0;
          ack_status_q <= ldrc_pkg::ST_OK;
          state_q      <= S_ACK;
          unique case (req_type_i)
            ldrc_pkg::REQ_ADD: begin
              if (count_q >= CW'(MAX_LAYERS)) begin
                ack_status_q <= ldrc_pkg::ST_FULL;
              end else begin
                left_q[count_q[IW-1:0]] <= pos_x_i;
                top_q[count_q[IW-1:0]]  <= pos_y_i;
                wid_q[count_q[IW-1:0]]  <= size_w_i;
                hgt_q[count_q[IW-1:0]]  <= size_h_i;
                vis_q[count_q[IW-1:0]]  <= show_i;
                dirty_q[count_q[IW-1:0]] <= 1'b1;
                ack_layer_q <= 3'(count_q);
                count_q     <= count_q + CW'(1);
              end
            end
            ldrc_pkg::REQ_VIS, ldrc_pkg::REQ_INVAL: begin
              ack_layer_q <= layer_index_i;
              if ({1'b0, layer_index_i} >= 4'(count_q)) begin
                ack_status_q <= ldrc_pkg::ST_RANGE;
              end else if (req_type_i == ldrc_pkg::REQ_INVAL ||
                           vis_q[layer_index_i[IW-1:0]] != show_i) begin
                vis_q[layer_index_i[IW-1:0]] <= (req_type_i == ldrc_pkg::REQ_INVAL) ?
                    vis_q[layer_index_i[IW-1:0]] : show_i;
                tgt_q     <= layer_index_i[IW-1:0];
                b_q       <= '0;
                covered_q <= 1'b0;
                state_q   <= S_INVAL;
              end
            end
            ldrc_pkg::REQ_DRAW: begin
              if (count_q != '0) begin
                a_q     <= last_idx;
                b_q     <= last_idx;
                state_q <= S_CLIP;
              end
            end
            ldrc_pkg::REQ_REDRW: begin
              a_q     <= last_idx;
              state_q <= (count_q != '0) ? S_RDRW : S_CANV;
            end
            default: ;
          endcase
        end
        S_INVAL: begin
          // Scan one other layer per cycle for a dirty cover.
          if (b_q != tgt_q && dirty_q[b_q] && rr.covers) covered_q <= 1'b1;
          if (b_q == last_idx) begin
            dirty_q[tgt_q] <= !(covered_q ||
                                (b_q != tgt_q && dirty_q[b_q] && rr.covers));
            state_q <= S_ACK;
          end else begin
            b_q <= b_q + IW'(1);
          end
        end
        S_CLIP: begin
          if (dirty_q[a_q] && vis_q[b_q] && rr.overlap) begin
            rv_q <= 1'b1; dt_q <= 1'b0; sc_q <= 1'b0; ib_q <= 1'b1; la_q <= 1'b0;
            st_q <= ldrc_pkg::ST_OK;
            sl_q <= 3'(b_q);
            dx_q <= rr.cl[15:0];
            dy_q <= rr.ct[15:0];
            sx_q <= 16'(rr.cl - rb.l);
            sy_q <= 16'(rr.ct - rb.t);
            bw_q <= rr.cw[11:0];
            bh_q <= rr.ch[11:0];
          end
          if (b_q == '0 || !dirty_q[a_q]) begin
            b_q <= last_idx;
            if (a_q == '0) begin
              a_q     <= last_idx;
              state_q <= target_q ? S_COPY : S_ACK;
            end else begin
              a_q <= a_q - IW'(1);
            end
          end else begin
            b_q <= b_q - IW'(1);
          end
        end
        S_COPY: begin
          if (dirty_q[a_q]) begin
            dirty_q[a_q] <= 1'b0;
            rv_q <= 1'b1; dt_q <= 1'b1; sc_q <= 1'b1; ib_q <= 1'b1; la_q <= 1'b0;
            st_q <= ldrc_pkg::ST_OK;
            sl_q <= 3'd0;
            dx_q <= left_q[a_q]; dy_q <= top_q[a_q];
            sx_q <= left_q[a_q]; sy_q <= top_q[a_q];
            bw_q <= wid_q[a_q];  bh_q <= hgt_q[a_q];
          end
          if (a_q == '0) state_q <= S_ACK;
          else a_q <= a_q - IW'(1);
        end
        S_RDRW: begin
          dirty_q[a_q] <= 1'b0;
          if (vis_q[a_q]) begin
            rv_q <= 1'b1; dt_q <= 1'b0; sc_q <= 1'b0; ib_q <= 1'b1; la_q <= 1'b0;
            st_q <= ldrc_pkg::ST_OK;
            sl_q <= 3'(a_q);
            dx_q <= left_q[a_q]; dy_q <= top_q[a_q];
            sx_q <= '0; sy_q <= '0;
            bw_q <= wid_q[a_q];  bh_q <= hgt_q[a_q];
          end
          if (a_q == '0) state_q <= S_CANV;
          else a_q <= a_q - IW'(1);
        end
        S_CANV: begin
          if (target_q) begin
            rv_q <= 1'b1; dt_q <= 1'b1; sc_q <= 1'b1; ib_q <= 1'b1; la_q <= 1'b0;
            st_q <= ldrc_pkg::ST_OK;
            sl_q <= 3'd0;
            dx_q <= '0; dy_q <= '0; sx_q <= '0; sy_q <= '0;
            bw_q <= cw_q; bh_q <= ch_q;
          end
          state_q <= S_ACK;
        end
        S_ACK: begin
          rv_q <= 1'b1; dt_q <= 1'b0; sc_q <= 1'b0; ib_q <= 1'b0; la_q <= 1'b1;
          st_q <= ack_status_q;
          sl_q <= ack_layer_q;
          dx_q <= '0; dy_q <= '0; sx_q <= '0; sy_q <= '0;
          bw_q <= '0; bh_q <= '0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o      = rv_q;
  assign dest_is_target_o = dt_q;
  assign dst_x_o          = dx_q;
  assign dst_y_o          = dy_q;
  assign src_is_canvas_o  = sc_q;
  assign src_layer_o      = sl_q;
  assign src_x_o          = sx_q;
  assign src_y_o          = sy_q;
  assign blit_w_o         = bw_q;
  assign blit_h_o         = bh_q;
  assign is_blit_o        = ib_q;
  assign last_o           = la_q;
  assign status_o         = st_q;

endmodule

// File: test/layer_dirty_rect_compositor_unit_test.sv
`timescale 1ns / 100ps

module layer_dirty_rect_compositor_unit_test;

  localparam int MAX_LAYERS = 4;
  // Request codes 5..7 are not decoded; the block only acknowledges them.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  // Longest request walk: every layer pair plus the copy pass, with margin.
  localparam int DRAIN_CYCLES = MAX_LAYERS * MAX_LAYERS + MAX_LAYERS + 12;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic               dest_is_target;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic               src_is_canvas;
    logic [2:0]         src_layer;
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic [11:0]        blit_w;
    logic [11:0]        blit_h;
    logic               is_blit;
    logic               last;
    logic [1:0]         status;
  } blit_cmd_t;

  // Layer table shadow plus the queue of blit commands and acks still owed.
  class compositor_scoreboard;
    int        lay_left[8], lay_top[8], lay_wid[8], lay_hgt[8];
    bit        lay_vis[8], lay_dirty[8];
    int        lay_count;
    bit        target_on;
    int        canvas_w, canvas_h;
    blit_cmd_t owed_cmds[$];
    int        errors, results_seen, blits_seen;

    function new();
      lay_count = 0;
      target_on = 1'b1;
      canvas_w  = 640;
      canvas_h  = 480;
      errors    = 0;
    endfunction

    function void owe(bit to_tgt, int dx, int dy, bit from_cv, int lay, int sx, int sy,
                      int w, int h, bit blit, bit lst, ldrc_pkg::status_e st);
      blit_cmd_t c;
      c.dest_is_target = to_tgt;
      c.dst_x = 16'(dx);
      c.dst_y = 16'(dy);
      c.src_is_canvas = from_cv;
      c.src_layer = 3'(lay);
      c.src_x = 16'(sx);
      c.src_y = 16'(sy);
      c.blit_w = 12'(w);
      c.blit_h = 12'(h);
      c.is_blit = blit;
      c.last = lst;
      c.status = st;
      owed_cmds.push_back(c);
    endfunction

    // Mark this layer dirty, unless another dirty layer covers it whole.
    function void mark_dirty(int i);
      bit covered;
      covered = 1'b0;
      for (int j = 0; j < lay_count; j++) begin
        if (j != i && lay_dirty[j] &&
            lay_left[j] <= lay_left[i] && lay_top[j] <= lay_top[i] &&
            lay_left[j] + lay_wid[j] >= lay_left[i] + lay_wid[i] &&
            lay_top[j] + lay_hgt[j] >= lay_top[i] + lay_hgt[i])
          covered = 1'b1;
      end
      lay_dirty[i] = !covered;
    endfunction

    function void note_request(logic [2:0] req, logic [2:0] idx, logic signed [15:0] px,
                               logic signed [15:0] py, logic [11:0] w, logic [11:0] h,
                               logic show);
      int il, it, ir, ib, ll, lt, lr, lb, cl, ct, cr, cb;
      if (req == ldrc_pkg::REQ_ADD) begin
        if (lay_count >= MAX_LAYERS) begin
          owe(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ldrc_pkg::ST_FULL);
        end else begin
          lay_left[lay_count]  = int'(px);
          lay_top[lay_count]   = int'(py);
          lay_wid[lay_count]   = int'(w);
          lay_hgt[lay_count]   = int'(h);
          lay_vis[lay_count]   = show;
          lay_dirty[lay_count] = 1'b1;
          owe(0, 0, 0, 0, lay_count, 0, 0, 0, 0, 0, 1, ldrc_pkg::ST_OK);
          lay_count++;
        end
      end else if (req == ldrc_pkg::REQ_VIS || req == ldrc_pkg::REQ_INVAL) begin
        if (idx >= lay_count) begin
          owe(0, 0, 0, 0, idx, 0, 0, 0, 0, 0, 1, ldrc_pkg::ST_RANGE);
        end else begin
          if (req == ldrc_pkg::REQ_INVAL) begin
            mark_dirty(idx);
          end else if (lay_vis[idx] != show) begin
            lay_vis[idx] = show;
            mark_dirty(idx);
          end
          owe(0, 0, 0, 0, idx, 0, 0, 0, 0, 0, 1, ldrc_pkg::ST_OK);
        end
      end else if (req == ldrc_pkg::REQ_DRAW) begin
        // Clip every visible layer into each dirty rectangle, back to front.
        for (int a = lay_count - 1; a >= 0; a--) begin
          if (!lay_dirty[a]) continue;
          il = lay_left[a];
          it = lay_top[a];
          ir = il + lay_wid[a] - 1;
          ib = it + lay_hgt[a] - 1;
          for (int b = lay_count - 1; b >= 0; b--) begin
            if (!lay_vis[b]) continue;
            ll = lay_left[b];
            lt = lay_top[b];
            lr = ll + lay_wid[b] - 1;
            lb = lt + lay_hgt[b] - 1;
            if (it > lb || il > lr || ir < ll || ib < lt) continue;
            cl = (ll < il) ? il : ll;
            ct = (lt < it) ? it : lt;
            cr = (lr < ir) ? lr : ir;
            cb = (lb < ib) ? lb : ib;
            owe(0, cl, ct, 0, b, cl - ll, ct - lt, cr - cl + 1, cb - ct + 1, 1, 0,
                ldrc_pkg::ST_OK);
          end
        end
        if (target_on) begin
          for (int a = lay_count - 1; a >= 0; a--) begin
            if (!lay_dirty[a]) continue;
            lay_dirty[a] = 1'b0;
            owe(1, lay_left[a], lay_top[a], 1, 0, lay_left[a], lay_top[a],
                lay_wid[a], lay_hgt[a], 1, 0, ldrc_pkg::ST_OK);
          end
        end
        owe(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ldrc_pkg::ST_OK);
      end else if (req == ldrc_pkg::REQ_REDRW) begin
        for (int a = lay_count - 1; a >= 0; a--) begin
          lay_dirty[a] = 1'b0;
          if (lay_vis[a])
            owe(0, lay_left[a], lay_top[a], 0, a, 0, 0, lay_wid[a], lay_hgt[a], 1, 0,
                ldrc_pkg::ST_OK);
        end
        if (target_on)
          owe(1, 0, 0, 1, 0, 0, 0, canvas_w, canvas_h, 1, 0, ldrc_pkg::ST_OK);
        owe(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ldrc_pkg::ST_OK);
      end else begin
        owe(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ldrc_pkg::ST_OK);
      end
    endfunction

    function void check_result(blit_cmd_t got);
      blit_cmd_t want;
      results_seen++;
      if (got.is_blit) blits_seen++;
      if (owed_cmds.size() == 0) begin
        $error("result with nothing owed: %h", got);
        errors++;
        return;
      end
      want = owed_cmds.pop_front();
      if (got.dest_is_target !== want.dest_is_target) begin
        $error("dest_is_target: expected %0d, got %0d", want.dest_is_target, got.dest_is_target);
        errors++;
      end
      if (got.dst_x !== want.dst_x) begin
        $error("dst_x: expected %0d, got %0d", want.dst_x, got.dst_x);
        errors++;
      end
      if (got.dst_y !== want.dst_y) begin
        $error("dst_y: expected %0d, got %0d", want.dst_y, got.dst_y);
        errors++;
      end
      if (got.src_is_canvas !== want.src_is_canvas) begin
        $error("src_is_canvas: expected %0d, got %0d", want.src_is_canvas, got.src_is_canvas);
        errors++;
      end
      if (got.src_layer !== want.src_layer) begin
        $error("src_layer: expected %0d, got %0d", want.src_layer, got.src_layer);
        errors++;
      end
      if (got.src_x !== want.src_x) begin
        $error("src_x: expected %0d, got %0d", want.src_x, got.src_x);
        errors++;
      end
      if (got.src_y !== want.src_y) begin
        $error("src_y: expected %0d, got %0d", want.src_y, got.src_y);
        errors++;
      end
      if (got.blit_w !== want.blit_w) begin
        $error("blit_w: expected %0d, got %0d", want.blit_w, got.blit_w);
        errors++;
      end
      if (got.blit_h !== want.blit_h) begin
        $error("blit_h: expected %0d, got %0d", want.blit_h, got.blit_h);
        errors++;
      end
      if (got.is_blit !== want.is_blit) begin
        $error("is_blit: expected %0d, got %0d", want.is_blit, got.is_blit);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [2:0]  req_type_i;
  logic [2:0]  layer_index_i;
  logic signed [15:0] pos_x_i, pos_y_i;
  logic [11:0] size_w_i, size_h_i;
  logic        show_i;
  logic        res_valid_o;
  blit_cmd_t   res_now;

  compositor_scoreboard owed;
  int cycle_count;
  int requests_sent;

  layer_dirty_rect_compositor_unit #(.MAX_LAYERS(MAX_LAYERS)) dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .req_type_i, .layer_index_i, .pos_x_i, .pos_y_i, .size_w_i,
    .size_h_i, .show_i, .res_valid_o,
    .dest_is_target_o(res_now.dest_is_target),
    .dst_x_o(res_now.dst_x),
    .dst_y_o(res_now.dst_y),
    .src_is_canvas_o(res_now.src_is_canvas),
    .src_layer_o(res_now.src_layer),
    .src_x_o(res_now.src_x),
    .src_y_o(res_now.src_y),
    .blit_w_o(res_now.blit_w),
    .blit_h_o(res_now.blit_h),
    .is_blit_o(res_now.is_blit),
    .last_o(res_now.last),
    .status_o(res_now.status)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Take every result at the edge that ends its cycle; the block cannot be stalled.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) owed.check_result(res_now);
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Write one register: setup cycle, then access cycle with penable.
  task automatic write_reg(logic [1:0] reg_idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == ldrc_pkg::ADDR_TARGET) owed.target_on = value[0];
    else if (reg_idx == ldrc_pkg::ADDR_CW) owed.canvas_w = int'(value[11:0]);
    else if (reg_idx == ldrc_pkg::ADDR_CH) owed.canvas_h = int'(value[11:0]);
  endtask

  // Hold off until every owed result has arrived and the walk has wound down.
  task automatic wait_quiet();
    while (owed.owed_cmds.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(logic tgt, logic [11:0] cw, logic [11:0] ch);
    wait_quiet();
    write_reg(ldrc_pkg::ADDR_TARGET, {31'd0, tgt});
    write_reg(ldrc_pkg::ADDR_CW, {20'd0, cw});
    write_reg(ldrc_pkg::ADDR_CH, {20'd0, ch});
  endtask

  // Wait for the block to go idle, then present one request for a single edge.
  task automatic send_request(logic [2:0] req, logic [2:0] idx, logic signed [15:0] px,
                              logic signed [15:0] py, logic [11:0] w, logic [11:0] h,
                              logic show, int gap);
    repeat (gap) @(negedge clk_i);
    // busy only moves at rising edges, so its value here holds through the next edge.
    while (busy) @(negedge clk_i);
    start         <= 1'b1;
    req_type_i    <= req;
    layer_index_i <= idx;
    pos_x_i       <= px;
    pos_y_i       <= py;
    size_w_i      <= w;
    size_h_i      <= h;
    show_i        <= show;
    @(negedge clk_i);
    owed.note_request(req, idx, px, py, w, h, show);
    requests_sent++;
    start <= 1'b0;
  endtask

  task automatic send_random(int gap);
    int pick;
    logic [2:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 8) req = ldrc_pkg::REQ_ADD;
    else if (pick < 33) req = ldrc_pkg::REQ_VIS;
    else if (pick < 58) req = ldrc_pkg::REQ_INVAL;
    else if (pick < 78) req = ldrc_pkg::REQ_DRAW;
    else if (pick < 90) req = ldrc_pkg::REQ_REDRW;
    else req = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    send_request(req, 3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                 12'($urandom), 12'($urandom), 1'($urandom), gap);
  endtask

  initial begin
    owed          = new();
    cycle_count   = 0;
    requests_sent = 0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    start         = 1'b0;
    req_type_i    = ldrc_pkg::REQ_ADD;
    layer_index_i = '0;
    pos_x_i       = '0;
    pos_y_i       = '0;
    size_w_i      = '0;
    size_h_i      = '0;
    show_i        = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, then a nested pair, a huge layer, a zero-width one and a full-table add.
    send_request(ldrc_pkg::REQ_VIS, 3'd0, 0, 0, 0, 0, 1'b1, 0);
    send_request(ldrc_pkg::REQ_INVAL, 3'd7, 0, 0, 0, 0, 1'b0, 0);
    send_request(ldrc_pkg::REQ_DRAW, 3'd0, 0, 0, 0, 0, 1'b0, 0);
    send_request(ldrc_pkg::REQ_ADD, 3'd0, 16'sd0, 16'sd0, 12'd100, 12'd100, 1'b1, 0);
    send_request(ldrc_pkg::REQ_ADD, 3'd0, 16'sd10, 16'sd10, 12'd20, 12'd20, 1'b1, 1);
    send_request(ldrc_pkg::REQ_ADD, 3'd0, 16'sd90, 16'sd90, 12'd4095, 12'd4095, 1'b1, 0);
    send_request(ldrc_pkg::REQ_ADD, 3'd0, 16'sh7fff, 16'sh8000, 12'd0, 12'd4095, 1'b0, 0);
    send_request(ldrc_pkg::REQ_ADD, 3'd0, 16'sh8000, 16'sh7fff, 12'd4095, 12'd0, 1'b1, 0);
    // Inner layer under a dirty outer one loses its mark; outer stays dirty.
    send_request(ldrc_pkg::REQ_INVAL, 3'd1, 0, 0, 0, 0, 1'b0, 0);
    send_request(ldrc_pkg::REQ_INVAL, 3'd0, 0, 0, 0, 0, 1'b0, 2);
    send_request(ldrc_pkg::REQ_VIS, 3'd2, 0, 0, 0, 0, 1'b1, 0);
    send_request(ldrc_pkg::REQ_VIS, 3'd3, 0, 0, 0, 0, 1'b1, 0);
    send_request(ldrc_pkg::REQ_VIS, 3'd4, 0, 0, 0, 0, 1'b1, 0);
    send_request(ldrc_pkg::REQ_DRAW, 3'd0, 0, 0, 0, 0, 1'b0, 0);
    send_request(ldrc_pkg::REQ_INVAL, 3'd2, 0, 0, 0, 0, 1'b0, 0);
    send_request(ldrc_pkg::REQ_REDRW, 3'd0, 0, 0, 0, 0, 1'b0, 0);
    send_request(REQ_UNUSED_LO, 3'd5, 0, 0, 0, 0, 1'b1, 0);
    send_request(REQ_UNUSED_HI, 3'd7, -1, -1, 12'hfff, 12'hfff, 1'b1, 0);
    send_request(3'd6, 3'd3, 0, 0, 0, 0, 1'b0, 0);

    // Drop the display target: draw keeps marks, redraw skips the canvas copy.
    configure(1'b0, 12'd0, 12'd0);
    send_request(ldrc_pkg::REQ_INVAL, 3'd3, 0, 0, 0, 0, 1'b0, 0);
    send_request(ldrc_pkg::REQ_DRAW, 3'd0, 0, 0, 0, 0, 1'b0, 0);
    send_request(ldrc_pkg::REQ_REDRW, 3'd0, 0, 0, 0, 0, 1'b0, 0);

    configure(1'b1, 12'd4095, 12'd4095);
    for (int i = 0; i < 390; i++) begin
      if (i % 80 == 40) configure(1'($urandom), 12'($urandom), 12'($urandom));
      if (i % 97 == 50) wait_quiet();
      if (i % 60 < 15) send_random(0);
      else send_random($urandom_range(0, 14));
    end
    configure(1'b1, 12'd0, 12'd4095);
    for (int i = 0; i < 10; i++) send_random($urandom_range(0, 14));

    wait_quiet();
    $display("Sent %0d requests; checked %0d results, %0d of them blits.",
             requests_sent, owed.results_seen, owed.blits_seen);
    $display("Covered full table, out-of-range index, covered invalidation and target off.");
    if (owed.errors == 0 && owed.owed_cmds.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
